>>> sv/circle_segment_intersection_top_assert.svh
// Assertion macros for the circle / segment intersection block.
`ifndef CIRCLE_SEGMENT_INTERSECTION_TOP_ASSERT_SVH
`define CIRCLE_SEGMENT_INTERSECTION_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CSI_ASSERT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSI_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/csi_pkg.sv
// Shared constants, types and latency helpers for the circle / segment intersection block.
package csi_pkg;

    localparam int COORD_BITS = 32;
    // Width of one partial-product chunk in the pipelined multipliers.
    localparam int MUL_CHUNK = 32;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_DEGENERATE = 2'd1,
        STATUS_NO_HIT     = 2'd2
    } status_t;

    // Multiplier latency: magnitude stage, one stage per chunk pair, sign stage.
    function automatic int mul_lat(input int aw, input int bw);
        return ((aw + MUL_CHUNK - 1) / MUL_CHUNK) * ((bw + MUL_CHUNK - 1) / MUL_CHUNK) + 2;
    endfunction

    // Divider latency: abs, offset, qw+1 quotient bits, saturate, sign.
    function automatic int div_lat(input int qw);
        return qw + 5;
    endfunction

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> sv/csi_if.sv
// Request and response channel interfaces.
interface csi_req_if #(parameter int COORD_BITS = csi_pkg::COORD_BITS);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic        [COORD_BITS-2:0] radius;

    modport source (output valid, start_x, start_y, end_x, end_y, radius, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, radius, output ready);
endinterface

interface csi_rsp_if #(parameter int COORD_BITS = csi_pkg::COORD_BITS);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    csi_pkg::status_t             status;

    modport source (output valid, point_x, point_y, status, input ready);
    modport sink   (input valid, point_x, point_y, status, output ready);
endinterface

>>> sv/csi_dly.sv
// Enabled delay line for payload that travels beside the arithmetic units.
module csi_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

>>> sv/csi_mul.sv
// Pipelined signed multiplier built from one chunk-by-chunk partial product per stage.
module csi_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int CH  = csi_pkg::MUL_CHUNK;
    localparam int NA  = (AW + CH - 1) / CH;
    localparam int NB  = (BW + CH - 1) / CH;
    localparam int NP  = NA * NB;
    localparam int PW  = AW + BW;
    localparam int AXW = NA * CH;
    localparam int BXW = NB * CH;

    logic [AW-1:0]  a_mag;
    logic [BW-1:0]  b_mag;
    logic [AXW-1:0] am_reg  [0:NP];
    logic [BXW-1:0] bm_reg  [0:NP];
    logic           neg_reg [0:NP];
    logic [PW-1:0]  acc_reg [0:NP];
    logic signed [PW-1:0] p_reg;

    // magnitudes and product sign
    assign a_mag = a[AW-1] ? AW'(~a + 1'b1) : AW'(a);
    assign b_mag = b[BW-1] ? BW'(~b + 1'b1) : BW'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            am_reg[0]  <= AXW'(a_mag);
            bm_reg[0]  <= BXW'(b_mag);
            neg_reg[0] <= a[AW-1] ^ b[BW-1];
            acc_reg[0] <= '0;
        end
    end

    // one chunk pair accumulated per stage
    for (genvar k = 1; k <= NP; k++)
    begin : g_pp
        localparam int IA = (k - 1) / NB;
        localparam int IB = (k - 1) % NB;
        localparam int SH = CH * (IA + IB);

        logic [2*CH-1:0] pp;

        assign pp = am_reg[k-1][IA*CH +: CH] * bm_reg[k-1][IB*CH +: CH];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                am_reg[k]  <= am_reg[k-1];
                bm_reg[k]  <= bm_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                acc_reg[k] <= acc_reg[k-1] + (PW'(pp) << SH);
            end
        end
    end

    // restore sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= neg_reg[NP] ? $signed(PW'(~acc_reg[NP] + 1'b1)) : $signed(acc_reg[NP]);
        end
    end

    assign p = p_reg;

endmodule

>>> sv/csi_sqrt.sv
// Pipelined floor square root, one result bit per stage.
module csi_sqrt #(
    parameter int IW = 128
) (
    input  logic            clk,
    input  logic            en,
    input  logic [IW-1:0]   rad,
    output logic [IW/2-1:0] root
);

    localparam int OW = IW / 2;
    localparam int RW = OW + 2;

    logic [RW-1:0] rem_reg  [1:OW];
    logic [OW-1:0] root_reg [1:OW];
    logic [IW-1:0] rad_reg  [1:OW];

    for (genvar k = 1; k <= OW; k++)
    begin : g_step
        logic [RW-1:0] rem_in;
        logic [OW-1:0] root_in;
        logic [IW-1:0] rad_in;
        logic [RW+1:0] cur;
        logic [RW+1:0] trial;

        if (k == 1)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign cur   = {rem_in, rad_in[IW-1 -: 2]};
        assign trial = (RW+2)'({root_in, 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cur >= trial)
                begin
                    rem_reg[k]  <= RW'(cur - trial);
                    root_reg[k] <= {root_in[OW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= RW'(cur);
                    root_reg[k] <= {root_in[OW-2:0], 1'b0};
                end
                rad_reg[k] <= rad_in << 2;
            end
        end
    end

    assign root = root_reg[OW];

endmodule

>>> sv/csi_div.sv
// Pipelined rounding divider: signed numerator, unsigned divisor, saturated signed quotient.
module csi_div #(
    parameter int NW = 131,
    parameter int DW = 66,
    parameter int QW = 32
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic signed [QW-1:0] quo
);

    localparam int CW = csi_pkg::imax(NW + 2, DW + QW + 1);
    localparam int NS = QW + 1;

    logic [NW-1:0] mag_reg;
    logic          nega_reg;
    logic [DW-1:0] dena_reg;
    logic [CW-1:0] rem_reg [0:NS];
    logic [DW:0]   d2_reg  [0:NS];
    logic          neg_reg [0:NS];
    logic [QW:0]   q_reg   [1:NS];
    logic [QW-1:0] qs_reg;
    logic          negs_reg;
    logic [QW-1:0] quo_reg;
    logic [QW:0]   lim;

    // magnitude
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= num[NW-1] ? NW'(~num + 1'b1) : NW'(num);
            nega_reg <= num[NW-1];
            dena_reg <= den;
        end
    end

    // round half away: (2*mag + den) / (2*den)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= CW'({mag_reg, 1'b0}) + CW'(dena_reg);
            d2_reg[0]  <= {dena_reg, 1'b0};
            neg_reg[0] <= nega_reg;
        end
    end

    // restoring steps, top bit first; a set top bit means saturation
    for (genvar k = 1; k <= NS; k++)
    begin : g_bit
        localparam int B = NS - k;

        logic [CW-1:0] shifted;
        logic [QW:0]   q_in;
        logic          ge;

        if (k == 1)
        begin : g_first
            assign q_in = '0;
        end
        else
        begin : g_next
            assign q_in = q_reg[k-1];
        end

        assign shifted = CW'(d2_reg[k-1]) << B;
        assign ge      = rem_reg[k-1] >= shifted;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? (rem_reg[k-1] - shifted) : rem_reg[k-1];
                d2_reg[k]  <= d2_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                q_reg[k]   <= {q_in[QW-1:0], ge};
            end
        end
    end

    // saturate magnitude
    assign lim = neg_reg[NS] ? ((QW+1)'(1) << (QW - 1)) : (((QW+1)'(1) << (QW - 1)) - 1'b1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qs_reg   <= (q_reg[NS] > lim) ? QW'(lim) : QW'(q_reg[NS]);
            negs_reg <= neg_reg[NS];
        end
    end

    // apply sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= negs_reg ? QW'(~qs_reg + 1'b1) : qs_reg;
        end
    end

    assign quo = $signed(quo_reg);

endmodule

>>> sv/circle_segment_intersection_top.sv
// Pipeline: stage 1, first multipliers, stage A, second multipliers, stage B, square root,
//   third multipliers, stage C, divider and output register; the square root and divider
//   chains are the longest part. The pipe stalls while the skid stage holds a beat.
// Throughput: one beat per cycle unless stalled; output register and skid decouple the response side.
// Reset: asynchronous active-low rst_n clears valid bits and the output/skid flags only.
`include "circle_segment_intersection_top_assert.svh"

module circle_segment_intersection_top #(
    parameter int COORD_BITS = csi_pkg::COORD_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    csi_req_if.sink     req,
    csi_rsp_if.source   rsp
);

    localparam int W    = COORD_BITS;
    localparam int MW1  = W + 1;
    localparam int P1W  = 2 * MW1;
    localparam int MW2  = 2 * W + 3;
    localparam int P2W  = 2 * MW2;
    localparam int SQW  = 4 * W;
    localparam int SW   = 2 * W;
    localparam int MW3B = 2 * W + 1;
    localparam int P3W  = MW1 + MW3B;
    localparam int NW   = 4 * W + 3;
    localparam int DW   = 2 * W + 2;
    localparam int L1   = csi_pkg::mul_lat(MW1, MW1);
    localparam int L2   = csi_pkg::mul_lat(MW2, MW2);
    localparam int L3   = csi_pkg::mul_lat(MW1, MW3B);
    localparam int LS   = SQW / 2;
    localparam int LD   = csi_pkg::div_lat(W);
    localparam int N    = 1 + L1 + 1 + L2 + 1 + LS + L3 + 1 + LD;

    logic         en;
    logic [N-1:0] vld_reg;
    logic         pv;

    // stage 1: inputs and differences
    logic signed [W-1:0]   x1_reg, y1_reg, x2_reg, y2_reg;
    logic        [W-2:0]   r_reg;
    logic signed [MW1-1:0] dx_reg, dy_reg;

    // first products
    logic signed [P1W-1:0] p_dxdx, p_dydy, p_x1y2, p_x2y1;
    logic signed [P1W-1:0] p_x1x1, p_y1y1, p_x2x2, p_y2y2, p_rr;
    logic [2*MW1-1:0]      dxy_a;

    // stage A
    logic [DW-1:0]         dr2_reg;
    logic signed [P1W-1:0] d_reg, n1_reg, n2_reg, r2_reg;
    logic signed [MW1-1:0] dxa_reg, dya_reg;
    logic                  flip_reg, zero_reg;

    // second products
    logic signed [P2W-1:0] p_rrdr, p_dd, p_ddy, p_ddx;
    logic [0:0]            zero_b;

    // stage B
    csi_pkg::status_t      status_reg;
    logic [SQW-1:0]        rad_reg;
    logic signed [P2W-1:0] disc;

    // square root and third products
    logic [SW-1:0]         s_root;
    logic [2*MW1-1:0]      dxy_m3;
    logic signed [P3W-1:0] p_tx, p_ty;
    logic [2*P2W-1:0]      dd_c;
    logic signed [P2W-1:0] ddy_c, ddx_c;
    logic [0:0]            flip_c;

    // stage C and divider
    logic signed [NW-1:0]  nx_reg, ny_reg;
    logic [DW-1:0]         dr2_dv;
    logic signed [W-1:0]   qx, qy;
    logic [1:0]            status_f;
    logic                  ok_f;
    logic signed [W-1:0]   pd_x, pd_y;

    // output register and skid
    logic                  ov_reg, sv_reg;
    logic signed [W-1:0]   out_x_reg, out_y_reg, sk_x_reg, sk_y_reg;
    csi_pkg::status_t      out_st_reg, sk_st_reg;

    // the pipe moves while the skid stage is free
    assign en        = !sv_reg;
    assign req.ready = en;

    // valid bits beside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], req.valid};
        end
    end

    assign pv = vld_reg[N-1];

    // stage 1
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= req.start_x;
            y1_reg <= req.start_y;
            x2_reg <= req.end_x;
            y2_reg <= req.end_y;
            r_reg  <= req.radius;
            dx_reg <= MW1'(req.end_x) - MW1'(req.start_x);
            dy_reg <= MW1'(req.end_y) - MW1'(req.start_y);
        end
    end

    csi_mul #(.AW(MW1), .BW(MW1)) u_m_dxdx (.clk(clk), .en(en), .a(dx_reg), .b(dx_reg),
        .p(p_dxdx));
    csi_mul #(.AW(MW1), .BW(MW1)) u_m_dydy (.clk(clk), .en(en), .a(dy_reg), .b(dy_reg),
        .p(p_dydy));
    csi_mul #(.AW(MW1), .BW(MW1)) u_m_x1y2 (.clk(clk), .en(en), .a(MW1'(x1_reg)),
        .b(MW1'(y2_reg)), .p(p_x1y2));
    csi_mul #(.AW(MW1), .BW(MW1)) u_m_x2y1 (.clk(clk), .en(en), .a(MW1'(x2_reg)),
        .b(MW1'(y1_reg)), .p(p_x2y1));
    csi_mul #(.AW(MW1), .BW(MW1)) u_m_x1x1 (.clk(clk), .en(en), .a(MW1'(x1_reg)),
        .b(MW1'(x1_reg)), .p(p_x1x1));
    csi_mul #(.AW(MW1), .BW(MW1)) u_m_y1y1 (.clk(clk), .en(en), .a(MW1'(y1_reg)),
        .b(MW1'(y1_reg)), .p(p_y1y1));
    csi_mul #(.AW(MW1), .BW(MW1)) u_m_x2x2 (.clk(clk), .en(en), .a(MW1'(x2_reg)),
        .b(MW1'(x2_reg)), .p(p_x2x2));
    csi_mul #(.AW(MW1), .BW(MW1)) u_m_y2y2 (.clk(clk), .en(en), .a(MW1'(y2_reg)),
        .b(MW1'(y2_reg)), .p(p_y2y2));
    csi_mul #(.AW(MW1), .BW(MW1)) u_m_rr (.clk(clk), .en(en), .a($signed(MW1'(r_reg))),
        .b($signed(MW1'(r_reg))), .p(p_rr));

    csi_dly #(.WIDTH(2*MW1), .DEPTH(L1)) u_d_dxy_a (.clk(clk), .en(en),
        .d({dx_reg, dy_reg}), .q(dxy_a));

    // stage A: squared length, cross term, endpoint norms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dr2_reg <= $unsigned(p_dxdx) + $unsigned(p_dydy);
            d_reg   <= p_x1y2 - p_x2y1;
            n1_reg  <= p_x1x1 + p_y1y1;
            n2_reg  <= p_x2x2 + p_y2y2;
            r2_reg  <= p_rr;
            dxa_reg <= $signed(dxy_a[2*MW1-1:MW1]);
            dya_reg <= $signed(dxy_a[MW1-1:0]);
        end
    end

    // side stage: direction sign and degenerate flag
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flip_reg <= n2_reg < n1_reg;
            zero_reg <= dr2_reg == '0;
        end
    end

    csi_mul #(.AW(MW2), .BW(MW2)) u_m_rrdr (.clk(clk), .en(en), .a(MW2'(r2_reg)),
        .b($signed({1'b0, dr2_reg})), .p(p_rrdr));
    csi_mul #(.AW(MW2), .BW(MW2)) u_m_dd (.clk(clk), .en(en), .a(MW2'(d_reg)),
        .b(MW2'(d_reg)), .p(p_dd));
    csi_mul #(.AW(MW2), .BW(MW2)) u_m_ddy (.clk(clk), .en(en), .a(MW2'(d_reg)),
        .b(MW2'(dya_reg)), .p(p_ddy));
    csi_mul #(.AW(MW2), .BW(MW2)) u_m_ddx (.clk(clk), .en(en), .a(MW2'(d_reg)),
        .b(MW2'(dxa_reg)), .p(p_ddx));

    csi_dly #(.WIDTH(1), .DEPTH(L2-1)) u_d_zero (.clk(clk), .en(en), .d(zero_reg),
        .q(zero_b));

    // stage B: discriminant and status
    assign disc = p_rrdr - p_dd;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_b[0])
            begin
                status_reg <= csi_pkg::STATUS_DEGENERATE;
            end
            else if (disc[P2W-1])
            begin
                status_reg <= csi_pkg::STATUS_NO_HIT;
            end
            else
            begin
                status_reg <= csi_pkg::STATUS_OK;
            end
            rad_reg <= disc[P2W-1] ? '0 : disc[SQW-1:0];
        end
    end

    csi_sqrt #(.IW(SQW)) u_sqrt (.clk(clk), .en(en), .rad(rad_reg), .root(s_root));

    csi_dly #(.WIDTH(2*MW1), .DEPTH(L2+1+LS)) u_d_dxy_m3 (.clk(clk), .en(en),
        .d({dxa_reg, dya_reg}), .q(dxy_m3));

    csi_mul #(.AW(MW1), .BW(MW3B)) u_m_tx (.clk(clk), .en(en),
        .a($signed(dxy_m3[2*MW1-1:MW1])), .b($signed({1'b0, s_root})), .p(p_tx));
    csi_mul #(.AW(MW1), .BW(MW3B)) u_m_ty (.clk(clk), .en(en),
        .a($signed(dxy_m3[MW1-1:0])), .b($signed({1'b0, s_root})), .p(p_ty));

    csi_dly #(.WIDTH(2*P2W), .DEPTH(1+LS+L3)) u_d_dd (.clk(clk), .en(en),
        .d({p_ddy, p_ddx}), .q(dd_c));
    csi_dly #(.WIDTH(1), .DEPTH(L2+LS+L3)) u_d_flip (.clk(clk), .en(en), .d(flip_reg),
        .q(flip_c));

    assign ddy_c = $signed(dd_c[2*P2W-1:P2W]);
    assign ddx_c = $signed(dd_c[P2W-1:0]);

    // stage C: numerators, far-side sign folded in as invert plus carry
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= NW'(ddy_c) + (NW'(p_tx) ^ {NW{flip_c[0]}}) + NW'(flip_c);
            ny_reg <= (NW'(p_ty) ^ {NW{flip_c[0]}}) + NW'(flip_c) - NW'(ddx_c);
        end
    end

    csi_dly #(.WIDTH(DW), .DEPTH(L2+LS+L3+2)) u_d_dr2 (.clk(clk), .en(en), .d(dr2_reg),
        .q(dr2_dv));

    csi_div #(.NW(NW), .DW(DW), .QW(W)) u_div_x (.clk(clk), .en(en), .num(nx_reg),
        .den(dr2_dv), .quo(qx));
    csi_div #(.NW(NW), .DW(DW), .QW(W)) u_div_y (.clk(clk), .en(en), .num(ny_reg),
        .den(dr2_dv), .quo(qy));

    csi_dly #(.WIDTH(2), .DEPTH(LS+L3+1+LD)) u_d_status (.clk(clk), .en(en),
        .d(status_reg), .q(status_f));

    // zero point on any error
    assign ok_f = csi_pkg::status_t'(status_f) == csi_pkg::STATUS_OK;
    assign pd_x = ok_f ? qx : '0;
    assign pd_y = ok_f ? qy : '0;

    // output register and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (!sv_reg)
        begin
            if (ov_reg && !rsp.ready)
            begin
                if (pv)
                begin
                    sv_reg <= 1'b1;
                end
            end
            else
            begin
                ov_reg <= pv;
            end
        end
        else if (rsp.ready)
        begin
            sv_reg <= 1'b0;
            ov_reg <= 1'b1;
        end
    end

    // output and skid payload
    always_ff @(posedge clk)
    begin
        if (!sv_reg)
        begin
            if (ov_reg && !rsp.ready)
            begin
                if (pv)
                begin
                    sk_x_reg  <= pd_x;
                    sk_y_reg  <= pd_y;
                    sk_st_reg <= csi_pkg::status_t'(status_f);
                end
            end
            else if (pv)
            begin
                out_x_reg  <= pd_x;
                out_y_reg  <= pd_y;
                out_st_reg <= csi_pkg::status_t'(status_f);
            end
        end
        else if (rsp.ready)
        begin
            out_x_reg  <= sk_x_reg;
            out_y_reg  <= sk_y_reg;
            out_st_reg <= sk_st_reg;
        end
    end

    assign rsp.valid   = ov_reg;
    assign rsp.point_x = out_x_reg;
    assign rsp.point_y = out_y_reg;
    assign rsp.status  = out_st_reg;

    // a held skid beat always sits behind a presented beat
    `CSI_ASSERT(a_skid_behind_out, clk, rst_n, sv_reg, ov_reg, "skid full without output beat")
    // error beats carry a zero point
    `CSI_ASSERT(a_err_zero_point, clk, rst_n, ov_reg && out_st_reg != csi_pkg::STATUS_OK, out_x_reg == '0 && out_y_reg == '0, "error beat with nonzero point")
    // a taken output with a full skid moves the skid beat forward
    `CSI_ASSERT_NEXT(a_skid_drain, clk, rst_n, sv_reg && rsp.ready, ov_reg && !sv_reg, "skid beat not forwarded")

endmodule

>>> test/testbench.sv
// Self-checking testbench for the circle / segment intersection block.
`timescale 1ns / 100ps

module testbench;

    localparam int W = csi_pkg::COORD_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic signed [W-1:0] point_x;
        logic signed [W-1:0] point_y;
        csi_pkg::status_t    status;
    } point_t;

    logic clk;
    logic rst_n;
    int   cycle;
    int   errors;
    int   hold_until;
    bit   idle_on;
    point_t pending_points[$];

    csi_req_if #(.COORD_BITS(W)) req ();
    csi_rsp_if #(.COORD_BITS(W)) rsp ();

    circle_segment_intersection_top #(.COORD_BITS(W)) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    // Clock and cycle counter with run limit
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Floor square root, bit by bit
    function automatic logic [255:0] floor_sqrt(input logic [255:0] v);
        logic [255:0] res;
        logic [255:0] b;
        logic [255:0] t;
        res = '0;
        b = 256'd1 << 254;
        while (b != 0 && b > v)
            b = b >> 2;
        while (b != 0)
        begin
            t = res + b;
            if (v >= t)
            begin
                v = v - t;
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // num / den rounded half away from zero, saturated to W bits
    function automatic logic signed [W-1:0] round_sat(input logic signed [255:0] num,
                                                      input logic signed [255:0] den);
        logic [255:0] mag;
        logic [255:0] q;
        logic [255:0] lim;
        bit neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q = (2 * mag + den) / (2 * den);
        lim = neg ? (256'd1 << (W - 1)) : ((256'd1 << (W - 1)) - 1);
        if (q > lim)
            q = lim;
        return neg ? -q[W-1:0] : q[W-1:0];
    endfunction

    // Lookahead point: exact wide integer evaluation of the intersection
    function automatic point_t lookahead_point(input logic signed [W-1:0] sx,
                                               input logic signed [W-1:0] sy,
                                               input logic signed [W-1:0] ex,
                                               input logic signed [W-1:0] ey,
                                               input logic [W-2:0] rad);
        logic signed [255:0] x1, y1, x2, y2, r, dx, dy, dr2, dd, n1, n2, disc, root, tx, ty;
        point_t p;
        x1 = 256'(sx);
        y1 = 256'(sy);
        x2 = 256'(ex);
        y2 = 256'(ey);
        r = $signed(256'(rad));
        dx = x2 - x1;
        dy = y2 - y1;
        dr2 = dx * dx + dy * dy;
        dd = x1 * y2 - x2 * y1;
        n1 = x1 * x1 + y1 * y1;
        n2 = x2 * x2 + y2 * y2;
        disc = r * r * dr2 - dd * dd;
        p.point_x = '0;
        p.point_y = '0;
        if (dr2 == 0)
            p.status = csi_pkg::STATUS_DEGENERATE;
        else if (disc < 0)
            p.status = csi_pkg::STATUS_NO_HIT;
        else
        begin
            root = $signed(floor_sqrt(disc));
            tx = dx * root;
            ty = dy * root;
            if (n2 < n1)
            begin
                tx = -tx;
                ty = -ty;
            end
            p.point_x = round_sat(dd * dy + tx, dr2);
            p.point_y = round_sat(ty - dd * dx, dr2);
            p.status = csi_pkg::STATUS_OK;
        end
        return p;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint exp);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle, field, got, exp);
        errors++;
    endtask

    // Append one expected point behind the ones already waiting
    task automatic expect_point(input point_t p);
        pending_points.insert(pending_points.size(), p);
    endtask

    // Send one segment beat, holding valid until accepted
    task automatic send_segment(input logic signed [W-1:0] sx, input logic signed [W-1:0] sy,
                                input logic signed [W-1:0] ex, input logic signed [W-1:0] ey,
                                input logic [W-2:0] rad);
        while (idle_on && $urandom_range(99) < 33)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.start_x <= sx;
        req.start_y <= sy;
        req.end_x   <= ex;
        req.end_y   <= ey;
        req.radius  <= rad;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        expect_point(lookahead_point(sx, sy, ex, ey, rad));
    endtask

    task automatic end_burst();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: random stalls plus long hold-off window
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (cycle < hold_until)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= !idle_on || ($urandom_range(99) >= 33);
    end

    // Compare each result beat with the oldest expected point
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_points.size() == 0)
            begin
                report_mismatch("result count", 1, 0);
            end
            else
            begin
                point_t e;
                e = pending_points.pop_front();
                if (rsp.status !== e.status)
                    report_mismatch("status", longint'(rsp.status), longint'(e.status));
                if (rsp.point_x !== e.point_x)
                    report_mismatch("point_x", longint'(rsp.point_x), longint'(e.point_x));
                if (rsp.point_y !== e.point_y)
                    report_mismatch("point_y", longint'(rsp.point_y), longint'(e.point_y));
            end
        end
    end

    // Random coordinate with random magnitude so that small and huge values both occur
    function automatic logic signed [W-1:0] rand_coord();
        logic signed [W-1:0] v;
        v = $urandom;
        return v >>> $urandom_range(W - 1);
    endfunction

    task automatic test_degenerate();
        send_segment(0, 0, 0, 0, 0);
        send_segment(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 31'h7fffffff);
        send_segment(32'sh00010000, -32'sh00020000, 32'sh00010000, -32'sh00020000, 31'h10000);
        end_burst();
    endtask

    task automatic test_directed();
        logic signed [W-1:0] r5;
        r5 = 32'sh00050000;
        // tangent: horizontal line at y = r
        send_segment(-32'sh00050000, r5, r5, r5, r5[W-2:0]);
        // equal endpoint norms
        send_segment(-32'sh00030000, 32'sh00040000, 32'sh00030000, 32'sh00040000, 31'h50000);
        // no intersection
        send_segment(32'sh00640000, 32'sh00640000, 32'sh00650000, 32'sh00640000, 31'h10000);
        // far endpoint nearer than start
        send_segment(32'sh000a0000, 0, 32'sh00010000, 0, 31'h30000);
        send_segment(0, 0, 32'sh000a0000, 0, 31'h30000);
        // zero radius, line through and not through origin
        send_segment(-32'sh00010000, 0, 32'sh00010000, 0, 0);
        send_segment(-32'sh00010000, 1, 32'sh00010000, 1, 0);
        // field extremes
        send_segment(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff);
        send_segment(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff);
        send_segment(32'sh80000000, 0, 32'sh7fffffff, 0, 31'h7fffffff);
        send_segment(0, 32'sh7fffffff, 0, 32'sh80000000, 31'h7fffffff);
        send_segment(32'sh80000000, 32'sh80000000, 32'sh80000001, 32'sh80000000, 31'h7fffffff);
        send_segment(-1, -1, 1, 1, 31'h7fffffff);
        send_segment(-1, 0, 0, -1, 1);
        send_segment(32'shffffffff, 32'shffffffff, 32'sh00000000, 32'sh00000001, 31'h1);
        end_burst();
    endtask

    // Mostly segments of random scale; some raw noise and degenerate beats
    task automatic test_random(input int count);
        logic signed [W-1:0] sx, sy, ex, ey;
        logic [W-2:0] rad;
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            sx = rand_coord();
            sy = rand_coord();
            if (pick < 10)
            begin
                sx = $urandom;
                sy = $urandom;
                ex = $urandom;
                ey = $urandom;
                rad = (W-1)'($urandom);
            end
            else if (pick < 15)
            begin
                ex = sx;
                ey = sy;
                rad = (W-1)'($urandom);
            end
            else
            begin
                ex = rand_coord();
                ey = rand_coord();
                // radius of random magnitude so the circle often cuts the segment
                rad = (W-1)'($urandom >> $urandom_range(W - 1, 1));
            end
            send_segment(sx, sy, ex, ey, rad);
        end
        end_burst();
    endtask

    task automatic test_backpressure();
        hold_until = cycle + 400;
        test_random(200);
    endtask

    task automatic wait_drain();
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        hold_until = 0;
        idle_on = 1'b1;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.start_x = '0;
        req.start_y = '0;
        req.end_x = '0;
        req.end_y = '0;
        req.radius = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_degenerate();
        test_directed();
        test_random(150);
        // long stretch with no idling on either side
        idle_on = 1'b0;
        test_random(100);
        idle_on = 1'b1;
        test_backpressure();
        test_random(50);

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/csi_pkg.sv
sv/csi_if.sv
sv/csi_dly.sv
sv/csi_mul.sv
sv/csi_sqrt.sv
sv/csi_div.sv
sv/circle_segment_intersection_top.sv
test/testbench.sv
